/* src/hrds_pkg.sv */
package hrds_pkg;

    // Field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PER_W    = 10;
    localparam int unsigned HALF_W   = PER_W - 1;
    localparam int unsigned REGION_W = 3;
    localparam int unsigned PROD_W   = 2 * BYTE_W;

    // Stream word widths
    localparam int unsigned S_TDATA_W = 6 * BYTE_W + TIME_W;
    localparam int unsigned M_TDATA_W = 4 * BYTE_W;

    // Color and strobe constants
    localparam int unsigned REGION_STEPS = 43;
    localparam int unsigned REGION_COUNT = 6;
    localparam int unsigned REGION_SCALE = 6;
    localparam int unsigned FULL_SCALE   = 255;
    localparam int unsigned BASE_PERIOD  = 1000;
    localparam int unsigned RATE_STEP    = 3;
    localparam int unsigned MIN_PERIOD   = 40;

    // Hue region codes
    localparam logic [REGION_W-1:0] REG_RED     = 3'd0;
    localparam logic [REGION_W-1:0] REG_YELLOW  = 3'd1;
    localparam logic [REGION_W-1:0] REG_GREEN   = 3'd2;
    localparam logic [REGION_W-1:0] REG_CYAN    = 3'd3;
    localparam logic [REGION_W-1:0] REG_BLUE    = 3'd4;

    // Remainder unit: bits retired per stage and stage count
    localparam int unsigned DIV_STAGES = 8;
    localparam int unsigned DIV_BITS   = TIME_W / DIV_STAGES;

    // Queue between the front and the back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Classified word handed from the front to the back
    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [BYTE_W-1:0]   frac;
        logic [BYTE_W-1:0]   sat;
        logic [BYTE_W-1:0]   val;
        logic [BYTE_W-1:0]   white;
        logic [BYTE_W-1:0]   master;
        logic                grey;
        logic                strobe_en;
        logic [PER_W-1:0]    period;
        logic [TIME_W-1:0]   time_ms;
    } class_t;

    // Scaled channel levels with the strobe decision inputs
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] white;
        logic              strobe_en;
        logic [HALF_W-1:0] half;
    } chan_t;

endpackage

/* src/hrds_front.sv */
module hrds_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // hue, saturation, brightness_value, white_level, master_level,
    // strobe_rate, time_ms (lowest bits first)
    input  logic [hrds_pkg::S_TDATA_W-1:0]    s_tdata,
    output hrds_pkg::class_t                  cls,
    output logic                              cls_valid,
    input  logic                              cls_ready
);
    import hrds_pkg::*;

    logic                valid_reg;
    class_t              cls_reg;
    class_t              cls_next;
    logic [BYTE_W-1:0]   hue;
    logic [BYTE_W-1:0]   rate;
    logic [REGION_W-1:0] region;
    logic [BYTE_W-1:0]   base;
    logic [BYTE_W-1:0]   diff;
    logic [PER_W-1:0]    per_raw;

    assign hue  = s_tdata[BYTE_W-1:0];
    assign rate = s_tdata[6*BYTE_W-1:5*BYTE_W];

    // Classify the word: hue region, position inside it, strobe period.
    always_comb begin
        region = '0;
        for (int k = 1; k < REGION_COUNT; k++) begin
            if (hue >= BYTE_W'(REGION_STEPS * k)) begin
                region = region + REGION_W'(1);
            end
        end
        base    = BYTE_W'(BYTE_W'(region) * BYTE_W'(REGION_STEPS));
        diff    = hue - base;
        per_raw = PER_W'(BASE_PERIOD) - PER_W'(rate) * PER_W'(RATE_STEP);

        cls_next.region    = region;
        cls_next.frac      = BYTE_W'(diff * BYTE_W'(REGION_SCALE));
        cls_next.sat       = s_tdata[2*BYTE_W-1:BYTE_W];
        cls_next.val       = s_tdata[3*BYTE_W-1:2*BYTE_W];
        cls_next.white     = s_tdata[4*BYTE_W-1:3*BYTE_W];
        cls_next.master    = s_tdata[5*BYTE_W-1:4*BYTE_W];
        cls_next.grey      = (s_tdata[2*BYTE_W-1:BYTE_W] == '0);
        cls_next.strobe_en = (rate != '0);
        cls_next.period    = (per_raw < PER_W'(MIN_PERIOD)) ? PER_W'(MIN_PERIOD) : per_raw;
        cls_next.time_ms   = s_tdata[S_TDATA_W-1:6*BYTE_W];
    end

    // The holding register frees up whenever the queue takes its word.
    assign s_tready = !valid_reg || cls_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cls_reg <= cls_next;
        end
    end

    assign cls       = cls_reg;
    assign cls_valid = valid_reg;

endmodule

/* src/hrds_queue.sv */
module hrds_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  hrds_pkg::class_t push_data,
    output logic             full,
    input  logic             pop,
    output hrds_pkg::class_t pop_data,
    output logic             not_empty
);
    import hrds_pkg::*;

    class_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/hrds_moddiv.sv */
module hrds_moddiv (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [hrds_pkg::PER_W-1:0]       period,
    input  logic [hrds_pkg::TIME_W-1:0]      time_ms,
    output logic [hrds_pkg::PER_W-1:0]       remainder
);
    import hrds_pkg::*;

    logic [PER_W-1:0]  rem_reg [DIV_STAGES];
    logic [TIME_W-1:0] tim_reg [DIV_STAGES];
    logic [PER_W-1:0]  per_reg [DIV_STAGES];

    // One group of restoring-division steps: shift in a bit, subtract if it fits.
    function automatic logic [PER_W-1:0] div_step(input logic [PER_W-1:0] rem_in,
                                                  input logic [DIV_BITS-1:0] bits,
                                                  input logic [PER_W-1:0] per);
        logic [PER_W:0]   acc;
        logic [PER_W-1:0] r;
        r = rem_in;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            acc = {r, bits[i]};
            if (acc >= {1'b0, per}) begin
                acc = acc - {1'b0, per};
            end
            r = acc[PER_W-1:0];
        end
        return r;
    endfunction

    // Each stage retires the next group of time bits, most significant first.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= div_step('0, time_ms[TIME_W-1 -: DIV_BITS], period);
                    tim_reg[k] <= time_ms << DIV_BITS;
                    per_reg[k] <= period;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= div_step(rem_reg[k-1], tim_reg[k-1][TIME_W-1 -: DIV_BITS],
                                           per_reg[k-1]);
                    tim_reg[k] <= tim_reg[k-1] << DIV_BITS;
                    per_reg[k] <= per_reg[k-1];
                end
            end
        end
    end

    assign remainder = rem_reg[DIV_STAGES-1];

endmodule

/* src/hrds_back.sv */
module hrds_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  hrds_pkg::class_t                  in_cls,
    output logic                              in_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // red, green, blue, white_out (lowest bits first)
    output logic [hrds_pkg::M_TDATA_W-1:0]    m_tdata
);
    import hrds_pkg::*;

    localparam int unsigned DLY_N = DIV_STAGES - 5;

    logic                  ce;
    logic [DIV_STAGES-1:0] vld_reg;
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [M_TDATA_W-1:0]  out_data_next;
    logic [PER_W-1:0]      rem;

    // Stage 1: saturation products
    logic [PROD_W-1:0]   s1_pmul_reg, s1_sf_reg, s1_sft_reg;
    logic [BYTE_W-1:0]   s1_val_reg, s1_white_reg, s1_master_reg;
    logic [REGION_W-1:0] s1_region_reg;
    logic                s1_grey_reg, s1_strobe_reg;
    logic [HALF_W-1:0]   s1_half_reg;

    // Stage 2: p, q and t products
    logic [BYTE_W-1:0]   s2_p_reg, s2_val_reg, s2_white_reg, s2_master_reg;
    logic [PROD_W-1:0]   s2_qmul_reg, s2_tmul_reg;
    logic [REGION_W-1:0] s2_region_reg;
    logic                s2_grey_reg, s2_strobe_reg;
    logic [HALF_W-1:0]   s2_half_reg;

    // Stage 3: selected red, green, blue
    logic [BYTE_W-1:0]   s3_r_reg, s3_g_reg, s3_b_reg, s3_white_reg, s3_master_reg;
    logic                s3_strobe_reg;
    logic [HALF_W-1:0]   s3_half_reg;
    logic [BYTE_W-1:0]   sel_r, sel_g, sel_b, q_c, t_c;

    // Stage 4: master products
    logic [PROD_W-1:0]   s4_r_reg, s4_g_reg, s4_b_reg, s4_w_reg;
    logic                s4_strobe_reg;
    logic [HALF_W-1:0]   s4_half_reg;

    // Stage 5 onward: scaled levels waiting for the remainder
    chan_t               s5_reg;
    chan_t               s5_next;
    chan_t               dly_reg [DLY_N];
    chan_t               last_c;

    // Divide a product of two bytes by 255, exact for any product of two bytes.
    function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] sum;
        sum = (PROD_W+1)'(x) + (PROD_W+1)'(x[PROD_W-1:BYTE_W]) + (PROD_W+1)'(1);
        return sum[PROD_W-1:BYTE_W];
    endfunction

    // The whole pipeline moves together when the output register can take a word.
    assign ce     = !out_valid_reg || m_tready;
    assign in_pop = ce && in_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg       <= {vld_reg[DIV_STAGES-2:0], in_valid};
            out_valid_reg <= vld_reg[DIV_STAGES-1];
        end
    end

    // Strobe remainder runs alongside the color stages.
    hrds_moddiv u_moddiv (
        .aclk      (aclk),
        .en        (ce),
        .period    (in_cls.period),
        .time_ms   (in_cls.time_ms),
        .remainder (rem)
    );

    // Stage 1.
    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_pmul_reg   <= PROD_W'(in_cls.val) * PROD_W'(BYTE_W'(FULL_SCALE) - in_cls.sat);
            s1_sf_reg     <= PROD_W'(in_cls.sat) * PROD_W'(in_cls.frac);
            s1_sft_reg    <= PROD_W'(in_cls.sat) * PROD_W'(BYTE_W'(FULL_SCALE) - in_cls.frac);
            s1_val_reg    <= in_cls.val;
            s1_white_reg  <= in_cls.white;
            s1_master_reg <= in_cls.master;
            s1_region_reg <= in_cls.region;
            s1_grey_reg   <= in_cls.grey;
            s1_strobe_reg <= in_cls.strobe_en;
            s1_half_reg   <= in_cls.period[PER_W-1:1];
        end
    end

    // Stage 2.
    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_p_reg      <= s1_pmul_reg[PROD_W-1:BYTE_W];
            s2_qmul_reg   <= PROD_W'(s1_val_reg)
                             * PROD_W'(BYTE_W'(FULL_SCALE) - s1_sf_reg[PROD_W-1:BYTE_W]);
            s2_tmul_reg   <= PROD_W'(s1_val_reg)
                             * PROD_W'(BYTE_W'(FULL_SCALE) - s1_sft_reg[PROD_W-1:BYTE_W]);
            s2_val_reg    <= s1_val_reg;
            s2_white_reg  <= s1_white_reg;
            s2_master_reg <= s1_master_reg;
            s2_region_reg <= s1_region_reg;
            s2_grey_reg   <= s1_grey_reg;
            s2_strobe_reg <= s1_strobe_reg;
            s2_half_reg   <= s1_half_reg;
        end
    end

    // Region select; grey overrides all regions.
    always_comb begin
        q_c = s2_qmul_reg[PROD_W-1:BYTE_W];
        t_c = s2_tmul_reg[PROD_W-1:BYTE_W];
        unique case (s2_region_reg)
            REG_RED: begin
                sel_r = s2_val_reg; sel_g = t_c;        sel_b = s2_p_reg;
            end
            REG_YELLOW: begin
                sel_r = q_c;        sel_g = s2_val_reg; sel_b = s2_p_reg;
            end
            REG_GREEN: begin
                sel_r = s2_p_reg;   sel_g = s2_val_reg; sel_b = t_c;
            end
            REG_CYAN: begin
                sel_r = s2_p_reg;   sel_g = q_c;        sel_b = s2_val_reg;
            end
            REG_BLUE: begin
                sel_r = t_c;        sel_g = s2_p_reg;   sel_b = s2_val_reg;
            end
            default: begin
                sel_r = s2_val_reg; sel_g = s2_p_reg;   sel_b = q_c;
            end
        endcase
        if (s2_grey_reg) begin
            sel_r = s2_val_reg;
            sel_g = s2_val_reg;
            sel_b = s2_val_reg;
        end
    end

    // Stage 3.
    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_r_reg      <= sel_r;
            s3_g_reg      <= sel_g;
            s3_b_reg      <= sel_b;
            s3_white_reg  <= s2_white_reg;
            s3_master_reg <= s2_master_reg;
            s3_strobe_reg <= s2_strobe_reg;
            s3_half_reg   <= s2_half_reg;
        end
    end

    // Stage 4: master dimmer products.
    always_ff @(posedge aclk) begin
        if (ce) begin
            s4_r_reg      <= PROD_W'(s3_r_reg) * PROD_W'(s3_master_reg);
            s4_g_reg      <= PROD_W'(s3_g_reg) * PROD_W'(s3_master_reg);
            s4_b_reg      <= PROD_W'(s3_b_reg) * PROD_W'(s3_master_reg);
            s4_w_reg      <= PROD_W'(s3_white_reg) * PROD_W'(s3_master_reg);
            s4_strobe_reg <= s3_strobe_reg;
            s4_half_reg   <= s3_half_reg;
        end
    end

    // Stage 5: scale back to bytes.
    always_comb begin
        s5_next.red       = div255(s4_r_reg);
        s5_next.green     = div255(s4_g_reg);
        s5_next.blue      = div255(s4_b_reg);
        s5_next.white     = div255(s4_w_reg);
        s5_next.strobe_en = s4_strobe_reg;
        s5_next.half      = s4_half_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s5_reg <= s5_next;
        end
    end

    // Delay line matching the remainder unit's depth.
    for (genvar k = 0; k < DLY_N; k++) begin : g_dly
        if (k == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (ce) begin
                    dly_reg[k] <= s5_reg;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (ce) begin
                    dly_reg[k] <= dly_reg[k-1];
                end
            end
        end
    end

    // Strobe gate into the output register.
    always_comb begin
        last_c = dly_reg[DLY_N-1];
        if (!last_c.strobe_en || (rem < PER_W'(last_c.half))) begin
            out_data_next = {last_c.white, last_c.blue, last_c.green, last_c.red};
        end else begin
            out_data_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* src/hsv_rgbw_dimmer_strobe_top.sv */
// HSV to RGBW converter with master dimmer and strobe gate.
// The input stream carries one word per lighting update: hue, saturation,
// value, white level, master level, strobe rate and a millisecond time.
// The output stream returns one word per input word with red, green, blue
// and white, each scaled by master/255 and forced to zero during the off
// half of the strobe square wave when the strobe rate is nonzero.
// A front stage registers and classifies each word (hue region, strobe
// period) and hands it through a four-word queue to a back pipeline.
// Throughput is one word per cycle while the receiver does not stall.
// From input acceptance to m_tvalid, the word loads the front register, is
// written into the queue, and then passes eight back stages set by the
// pipelined remainder unit (four time bits per stage) and the output
// register.
// When the receiver stalls, the back pipeline holds in place while the
// queue keeps taking words; s_tready falls once the queue and the front
// register are both full. Reset clears all valid flags and the queue;
// no words are in flight afterwards.
module hsv_rgbw_dimmer_strobe_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // hue, saturation, brightness_value, white_level, master_level,
    // strobe_rate, time_ms (lowest bits first)
    input  logic [hrds_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // red, green, blue, white_out (lowest bits first)
    output logic [hrds_pkg::M_TDATA_W-1:0]    m_tdata
);
    import hrds_pkg::*;

    class_t front_cls;
    logic   front_valid;
    logic   queue_full;
    class_t queue_cls;
    logic   queue_not_empty;
    logic   back_pop;

    // Front: accept and classify.
    hrds_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cls       (front_cls),
        .cls_valid (front_valid),
        .cls_ready (!queue_full)
    );

    // Queue decoupling the two sides.
    hrds_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_data (front_cls),
        .full      (queue_full),
        .pop       (back_pop),
        .pop_data  (queue_cls),
        .not_empty (queue_not_empty)
    );

    // Back: color math, dimmer, strobe.
    hrds_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (queue_not_empty),
        .in_cls   (queue_cls),
        .in_pop   (back_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* tb/sv/hsv_rgbw_dimmer_strobe_top_tb.sv */
module hsv_rgbw_dimmer_strobe_top_tb;

    import hrds_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_WORDS = 1700;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned HOLD_CYCLES  = 200;

    // Input word, hue in the lowest bits.
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [BYTE_W-1:0] strobe_rate;
        logic [BYTE_W-1:0] master_level;
        logic [BYTE_W-1:0] white_level;
        logic [BYTE_W-1:0] brightness_value;
        logic [BYTE_W-1:0] saturation;
        logic [BYTE_W-1:0] hue;
    } color_req_t;

    // Output word, red in the lowest bits.
    typedef struct packed {
        logic [BYTE_W-1:0] white_out;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
    } rgbw_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    color_req_t  update_q[$];
    rgbw_t       expected_rgbw_q[$];
    color_req_t  offered_word;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned results_seen = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned hold_left = 0;

    hsv_rgbw_dimmer_strobe_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Expected output word for one lighting update.
    function automatic rgbw_t predict_rgbw(color_req_t c);
        int unsigned h, s, v, f, p, q, t, r, g, b, w, m, period;
        logic [REGION_W-1:0] region;
        rgbw_t res;
        h = c.hue;
        s = c.saturation;
        v = c.brightness_value;
        m = c.master_level;
        if (s == 0) begin
            r = v;
            g = v;
            b = v;
        end else begin
            region = REGION_W'(h / REGION_STEPS);
            f = (h - (h / REGION_STEPS) * REGION_STEPS) * REGION_SCALE;
            p = (v * (FULL_SCALE - s)) >> 8;
            q = (v * (FULL_SCALE - ((s * f) >> 8))) >> 8;
            t = (v * (FULL_SCALE - ((s * (FULL_SCALE - f)) >> 8))) >> 8;
            case (region)
                REG_RED: begin
                    r = v; g = t; b = p;
                end
                REG_YELLOW: begin
                    r = q; g = v; b = p;
                end
                REG_GREEN: begin
                    r = p; g = v; b = t;
                end
                REG_CYAN: begin
                    r = p; g = q; b = v;
                end
                REG_BLUE: begin
                    r = t; g = p; b = v;
                end
                default: begin
                    r = v; g = p; b = q;
                end
            endcase
        end
        r = (r * m) / FULL_SCALE;
        g = (g * m) / FULL_SCALE;
        b = (b * m) / FULL_SCALE;
        w = (c.white_level * m) / FULL_SCALE;

        // Strobe gate: off half of the square wave blanks every channel.
        if (c.strobe_rate != 0) begin
            period = BASE_PERIOD - c.strobe_rate * RATE_STEP;
            if (period < MIN_PERIOD) begin
                period = MIN_PERIOD;
            end
            if ((c.time_ms % period) >= (period / 2)) begin
                r = 0; g = 0; b = 0; w = 0;
            end
        end
        res.red       = BYTE_W'(r);
        res.green     = BYTE_W'(g);
        res.blue      = BYTE_W'(b);
        res.white_out = BYTE_W'(w);
        return res;
    endfunction

    // Idle length for either side; stretches without idling come and go.
    function automatic int unsigned pick_idle(int unsigned cyc);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (cyc[10:9] == 2'd0) begin
            return 0;
        end
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got,
                 want);
        error_count++;
    endtask

    task automatic add_update(input int unsigned h, input int unsigned s,
                              input int unsigned v, input int unsigned w,
                              input int unsigned m, input int unsigned rate,
                              input logic [TIME_W-1:0] t);
        color_req_t c;
        c.hue              = BYTE_W'(h);
        c.saturation       = BYTE_W'(s);
        c.brightness_value = BYTE_W'(v);
        c.white_level      = BYTE_W'(w);
        c.master_level     = BYTE_W'(m);
        c.strobe_rate      = BYTE_W'(rate);
        c.time_ms          = t;
        update_q.push_back(c);
    endtask

    // Cycle counter with the run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Driver: offers pending words, records each accepted word's prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_rgbw_q.push_back(predict_rgbw(offered_word));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (update_q.size() > 0) begin
                    offered_word = update_q.pop_front();
                    s_tdata  <= offered_word;
                    s_tvalid <= 1'b1;
                    send_gap <= pick_idle(cycle_count);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs after two chosen results; the sender keeps
    // offering during a hold, so the block backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (m_tvalid && m_tready
                     && (results_seen == 300 || results_seen == 1200)) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor: random receiver stalls and field checks.
    always @(posedge aclk) begin
        rgbw_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_rgbw_q.size() == 0) begin
                    report_mismatch("unexpected word", got, 0);
                end else begin
                    want = expected_rgbw_q.pop_front();
                    if (got.red != want.red) begin
                        report_mismatch("red", got.red, want.red);
                    end
                    if (got.green != want.green) begin
                        report_mismatch("green", got.green, want.green);
                    end
                    if (got.blue != want.blue) begin
                        report_mismatch("blue", got.blue, want.blue);
                    end
                    if (got.white_out != want.white_out) begin
                        report_mismatch("white_out", got.white_out, want.white_out);
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                recv_stall <= pick_idle(cycle_count + 300);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int unsigned roll, h, s, v, w, m, rate;
        logic [TIME_W-1:0] t;

        // Directed words: extremes, every hue region edge, grey, strobe edges.
        add_update(0, 0, 0, 0, 0, 0, 32'd0);
        add_update(255, 255, 255, 255, 255, 255, 32'hFFFF_FFFF);
        add_update(100, 0, 200, 50, 255, 0, 32'd12345);
        add_update(0, 255, 255, 0, 255, 0, 32'd0);
        add_update(42, 255, 255, 0, 255, 0, 32'd0);
        add_update(43, 255, 255, 0, 255, 0, 32'd0);
        add_update(85, 200, 255, 0, 255, 0, 32'd0);
        add_update(86, 200, 255, 0, 255, 0, 32'd0);
        add_update(128, 180, 240, 0, 255, 0, 32'd0);
        add_update(129, 180, 240, 0, 255, 0, 32'd0);
        add_update(171, 255, 200, 0, 255, 0, 32'd0);
        add_update(172, 255, 200, 0, 255, 0, 32'd0);
        add_update(214, 128, 255, 0, 255, 0, 32'd0);
        add_update(215, 128, 255, 0, 255, 0, 32'd0);
        add_update(255, 255, 255, 255, 128, 0, 32'd0);
        add_update(30, 255, 255, 255, 0, 0, 32'd7);
        add_update(10, 150, 255, 255, 255, 255, 32'd116);
        add_update(10, 150, 255, 255, 255, 255, 32'd117);
        add_update(10, 150, 255, 255, 255, 255, 32'd234);
        add_update(10, 150, 255, 255, 255, 255, 32'd235);
        add_update(60, 255, 255, 100, 255, 1, 32'd497);
        add_update(60, 255, 255, 100, 255, 1, 32'd498);
        add_update(60, 255, 255, 100, 255, 1, 32'hFFFF_FFFF);
        add_update(200, 90, 77, 33, 200, 128, 32'h8000_0000);

        // Random words with biased corners.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            h = $urandom_range(0, 255);
            roll = $urandom_range(0, 99);
            s = (roll < 10) ? 0 : (roll < 15) ? 255 : $urandom_range(0, 255);
            v = $urandom_range(0, 255);
            w = $urandom_range(0, 255);
            roll = $urandom_range(0, 99);
            m = (roll < 5) ? 0 : (roll < 10) ? 255 : $urandom_range(0, 255);
            roll = $urandom_range(0, 99);
            rate = (roll < 30) ? 0 : (roll < 35) ? 255 : $urandom_range(1, 255);
            t = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 2000);
            add_update(h, s, v, w, m, rate, t);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (update_q.size() > 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (expected_rgbw_q.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_rgbw_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
